@@ hdl/multi_queue_with_urgent_front_insert_assert.svh @@
// Assertion macros for the queue bank; they sample on clk and pause while rst_n is low.
`ifndef MULTI_QUEUE_WITH_URGENT_FRONT_INSERT_ASSERT_SVH
`define MULTI_QUEUE_WITH_URGENT_FRONT_INSERT_ASSERT_SVH

// Implication checked in the same cycle.
`define MQUFI_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence checked after the delay given by dly.
`define MQUFI_CHECK_LATER(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

@@ hdl/mqufi_pkg.sv @@
package mqufi_pkg;

  localparam int NUM_QUEUES  = 32;
  localparam int QUEUE_DEPTH = 8;
  localparam int ID_WIDTH    = 16;

  localparam int QIDX_IN_W = 5;
  localparam int ID_IN_W   = 16;
  localparam int CNT_W     = 4;
  localparam int LIMIT_W   = 4;

  localparam int Q_W       = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LEN_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W     = (LEN_W > LIMIT_W) ? LEN_W : LIMIT_W;
  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int FIFO_DEPTH = 2;
  localparam int FP_W       = $clog2(FIFO_DEPTH);
  localparam int FC_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TAKE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                cmd;
    logic [Q_W-1:0]      qidx;
    logic [ID_WIDTH-1:0] id;
    logic                urgent;
  } req_t;

  typedef struct packed {
    logic                urgent;
    logic [ID_WIDTH-1:0] id;
  } entry_t;

  // Fold the 5-bit request index onto the queues that exist.
  function automatic logic [Q_W-1:0] qidx_map(input logic [QIDX_IN_W-1:0] v);
    logic [Q_W-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << QIDX_IN_W); i++) begin
      if (v == QIDX_IN_W'(i)) begin
        r = Q_W'(i % NUM_QUEUES);
      end
    end
    return r;
  endfunction

endpackage

@@ hdl/multi_queue_with_urgent_front_insert.sv @@
// Bank of 32 bounded deques of up to 8 entry ids each. Pulse start while busy
// is low to hand in one item: in_cmd selects add or take, in_queue_index the
// queue. An add puts in_entry_id at the tail, or at the head when in_urgent is
// set, so urgent entries leave last-in first-out among themselves; an add to a
// queue holding max_len entries is refused with status full. A take pops the
// head and returns its id and urgency mark, or reports empty. Every item gives
// exactly one result: the item is written into the input queue, then the back
// end registers its result and out_valid is high for a single cycle; the
// receiver cannot stall, so capture it then. Sustained rate is one item per
// clock: per cycle the back end does one read-modify-write of the addressed
// queue's head pointer and length, one read of the entry memory at the head
// slot and, for an add that is not refused, one write at the new slot. A
// two-deep input queue sits in front and is drained every cycle, so busy
// stays low. Queue lengths clear at reset with no sweep; the entry memory
// is not cleared since only stored slots are ever read. max_len is written at
// byte address 0 of the APB port, reset 8; only the low 4 bits of pwdata are
// kept, values 9 to 15 act as 8 and 0 refuses every add.

`include "multi_queue_with_urgent_front_insert_assert.svh"

module multi_queue_with_urgent_front_insert (
  input  logic         clk,
  input  logic         rst_n,
  // item channel
  input  logic         start,
  output logic         busy,
  input  logic         in_cmd,
  input  logic [4:0]   in_queue_index,
  input  logic [15:0]  in_entry_id,
  input  logic         in_urgent,
  // result channel
  output logic         out_valid,
  output logic [1:0]   out_result_status,
  output logic [15:0]  out_served_id,
  output logic         out_served_urgent,
  output logic [3:0]   out_queue_count,
  // register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic REG_MAX_LEN = 1'b0;

  logic [mqufi_pkg::LIMIT_W-1:0] max_len_r;
  logic                          req_valid;
  mqufi_pkg::req_t               req;
  logic                          reg_wr;

  // Register port: zero wait states, one 4-bit register in the low bits of the word.
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MAX_LEN) ? 32'(max_len_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= mqufi_pkg::LIMIT_W'(mqufi_pkg::QUEUE_DEPTH);
    end else if (reg_wr && paddr[2] == REG_MAX_LEN) begin
      // hold only the low bits; the limit clamp lives in the back end
      max_len_r <= pwdata[mqufi_pkg::LIMIT_W-1:0];
    end
  end

  // Front: accept and decode items into the short request queue.
  mqufi_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_cmd         (in_cmd),
    .in_queue_index (in_queue_index),
    .in_entry_id    (in_entry_id),
    .in_urgent      (in_urgent),
    .busy           (busy),
    .req_valid      (req_valid),
    .req            (req),
    .req_pop        (req_valid)
  );

  // Back: drain one request per cycle against the ring pointers and entry memory.
  mqufi_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req_valid),
    .req               (req),
    .max_len           (max_len_r),
    .out_valid         (out_valid),
    .out_result_status (out_result_status),
    .out_served_id     (out_served_id),
    .out_served_urgent (out_served_urgent),
    .out_queue_count   (out_queue_count)
  );

  // Every accepted item yields its result after the input queue and the back end's result register.
  `MQUFI_CHECK_LATER(a_result_latency, start && !busy, 2, out_valid, "accepted item gave no result")
  // Refused or empty results never carry a served entry.
  `MQUFI_CHECK_NOW(a_no_serve_on_fail, out_valid && out_result_status != mqufi_pkg::ST_DONE, out_served_id == 16'd0 && !out_served_urgent, "served data on failed request")
  // An empty report leaves the queue length at zero.
  `MQUFI_CHECK_NOW(a_empty_count, out_valid && out_result_status == mqufi_pkg::ST_EMPTY, out_queue_count == 4'd0, "empty status with nonzero count")
  // Lengths never pass the queue depth.
  `MQUFI_CHECK_NOW(a_count_bound, out_valid, out_queue_count <= 4'(mqufi_pkg::QUEUE_DEPTH), "queue count above depth")

endmodule

@@ hdl/mqufi_front.sv @@
module mqufi_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        in_cmd,
  input  logic [4:0]                  in_queue_index,
  input  logic [15:0]                 in_entry_id,
  input  logic                        in_urgent,
  output logic                        busy,
  output logic                        req_valid,
  output mqufi_pkg::req_t             req,
  input  logic                        req_pop
);

  mqufi_pkg::req_t                  fifo_r [mqufi_pkg::FIFO_DEPTH];
  logic [mqufi_pkg::FP_W-1:0]       wr_ptr_r;
  logic [mqufi_pkg::FP_W-1:0]       rd_ptr_r;
  logic [mqufi_pkg::FC_W-1:0]       cnt_r;
  logic [mqufi_pkg::FC_W-1:0]       cnt_nxt;
  logic                             push;
  logic                             pop;
  mqufi_pkg::req_t                  in_req;

  assign busy      = (cnt_r == mqufi_pkg::FC_W'(mqufi_pkg::FIFO_DEPTH));
  assign push      = start && !busy;
  assign req_valid = (cnt_r != '0);
  assign pop       = req_pop && req_valid;
  assign req       = fifo_r[rd_ptr_r];

  always_comb begin
    in_req.cmd    = in_cmd;
    in_req.qidx   = mqufi_pkg::qidx_map(in_queue_index);
    in_req.id     = mqufi_pkg::ID_WIDTH'(in_entry_id);
    in_req.urgent = in_urgent;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= in_req;
    end
  end

endmodule

@@ hdl/mqufi_back.sv @@
module mqufi_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 req_valid,
  input  mqufi_pkg::req_t                      req,
  input  logic [mqufi_pkg::LIMIT_W-1:0]        max_len,
  output logic                                 out_valid,
  output logic [1:0]                           out_result_status,
  output logic [15:0]                          out_served_id,
  output logic                                 out_served_urgent,
  output logic [3:0]                           out_queue_count
);

  localparam int SUM_W = mqufi_pkg::LEN_W + 1;

  logic [mqufi_pkg::PTR_W-1:0]   head_r [mqufi_pkg::NUM_QUEUES];
  logic [mqufi_pkg::LEN_W-1:0]   len_r  [mqufi_pkg::NUM_QUEUES];
  mqufi_pkg::entry_t             mem    [mqufi_pkg::MEM_DEPTH];
  mqufi_pkg::entry_t             rd_data_r;

  logic                          out_valid_r;
  logic [1:0]                    status_r;
  logic [mqufi_pkg::CNT_W-1:0]   count_r;
  logic                          take_ok_r;

  logic [mqufi_pkg::PTR_W-1:0]   head;
  logic [mqufi_pkg::LEN_W-1:0]   len;
  logic [mqufi_pkg::CMP_W-1:0]   lim_cmp;
  logic                          full;
  logic                          empty;
  logic [SUM_W-1:0]              tail_sum;
  logic [mqufi_pkg::PTR_W-1:0]   tail;
  logic [mqufi_pkg::PTR_W-1:0]   head_dec;
  logic [mqufi_pkg::PTR_W-1:0]   head_inc;
  logic [mqufi_pkg::PTR_W-1:0]   head_nxt;
  logic [mqufi_pkg::LEN_W-1:0]   len_nxt;
  logic [mqufi_pkg::PTR_W-1:0]   wr_slot;
  logic                          wr_en;
  logic                          take_ok_nxt;
  logic [1:0]                    status_nxt;
  logic [mqufi_pkg::ADDR_W-1:0]  base_addr;
  logic [mqufi_pkg::ADDR_W-1:0]  wr_addr;
  logic [mqufi_pkg::ADDR_W-1:0]  rd_addr;
  mqufi_pkg::entry_t             wr_data;

  assign head = head_r[req.qidx];
  assign len  = len_r[req.qidx];

  assign lim_cmp = (mqufi_pkg::CMP_W'(max_len) > mqufi_pkg::CMP_W'(mqufi_pkg::QUEUE_DEPTH))
                 ? mqufi_pkg::CMP_W'(mqufi_pkg::QUEUE_DEPTH) : mqufi_pkg::CMP_W'(max_len);
  assign full  = (mqufi_pkg::CMP_W'(len) >= lim_cmp);
  assign empty = (len == '0);

  // Ring arithmetic: values stay below twice the depth, so one compare-subtract wraps.
  assign tail_sum = SUM_W'(head) + SUM_W'(len);
  assign tail     = (tail_sum >= SUM_W'(mqufi_pkg::QUEUE_DEPTH))
                  ? mqufi_pkg::PTR_W'(tail_sum - SUM_W'(mqufi_pkg::QUEUE_DEPTH))
                  : mqufi_pkg::PTR_W'(tail_sum);
  assign head_dec = (head == '0) ? mqufi_pkg::PTR_W'(mqufi_pkg::QUEUE_DEPTH - 1)
                                 : head - 1'b1;
  assign head_inc = (head == mqufi_pkg::PTR_W'(mqufi_pkg::QUEUE_DEPTH - 1)) ? '0
                                 : head + 1'b1;

  always_comb begin
    head_nxt    = head;
    len_nxt     = len;
    wr_slot     = tail;
    wr_en       = 1'b0;
    take_ok_nxt = 1'b0;
    status_nxt  = mqufi_pkg::ST_DONE;
    if (req.cmd == mqufi_pkg::CMD_ADD) begin
      if (full) begin
        status_nxt = mqufi_pkg::ST_FULL;
      end else begin
        wr_en   = 1'b1;
        len_nxt = len + 1'b1;
        if (req.urgent) begin
          head_nxt = head_dec;
          wr_slot  = head_dec;
        end
      end
    end else begin
      if (empty) begin
        status_nxt = mqufi_pkg::ST_EMPTY;
      end else begin
        take_ok_nxt = 1'b1;
        head_nxt    = head_inc;
        len_nxt     = len - 1'b1;
      end
    end
  end

  assign base_addr = mqufi_pkg::ADDR_W'(req.qidx) *
                     mqufi_pkg::ADDR_W'(mqufi_pkg::QUEUE_DEPTH);
  assign wr_addr   = base_addr + mqufi_pkg::ADDR_W'(wr_slot);
  assign rd_addr   = base_addr + mqufi_pkg::ADDR_W'(head);

  always_comb begin
    wr_data.urgent = req.urgent;
    wr_data.id     = req.id;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mqufi_pkg::NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        len_r[i]  <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= req_valid;
      if (req_valid) begin
        head_r[req.qidx] <= head_nxt;
        len_r[req.qidx]  <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      status_r  <= status_nxt;
      take_ok_r <= take_ok_nxt;
      count_r   <= mqufi_pkg::CNT_W'(mqufi_pkg::CMP_W'(len_nxt));
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_status = status_r;
  assign out_served_id     = take_ok_r ? 16'(rd_data_r.id) : 16'd0;
  assign out_served_urgent = take_ok_r && rd_data_r.urgent;
  assign out_queue_count   = count_r;

endmodule
